### sv/mlbc_pkg.sv
// Shared types and constants for the multi-LED blink controller.
// No dependencies.
package mlbc_pkg;

  localparam int NUM_LEDS_DEF = 4;
  localparam int SHOWN_LEDS   = 4;

  localparam int OP_W    = 3;
  localparam int IDX_W_F = 2;
  localparam int CNT_W   = 16;

  localparam logic [OP_W-1:0] OP_TICK         = 3'd0;
  localparam logic [OP_W-1:0] OP_SET          = 3'd1;
  localparam logic [OP_W-1:0] OP_TOGGLE       = 3'd2;
  localparam logic [OP_W-1:0] OP_BLINK_ON     = 3'd3;
  localparam logic [OP_W-1:0] OP_BLINK_OFF    = 3'd4;
  localparam logic [OP_W-1:0] OP_BLINK_TOGGLE = 3'd5;
  localparam logic [OP_W-1:0] OP_BLINK_TIMES  = 3'd6;

  // Per-LED timing entry held in the state memory.
  typedef struct packed {
    logic             saved_level;
    logic             endless;
    logic [CNT_W-1:0] flip_interval;
    logic [CNT_W-1:0] elapsed_ticks;
    logic [CNT_W-1:0] cycles_remaining;
  } led_entry_t;

endpackage

### sv/mlbc_if.sv
// Valid/ready channels for command beats and result beats.
// Depends on mlbc_pkg.
interface mlbc_cmd_if;
  import mlbc_pkg::*;
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    operation;
  logic [IDX_W_F-1:0] led_index;
  logic               on_level;
  logic [CNT_W-1:0]   interval;
  logic [CNT_W-1:0]   blink_count;

  modport source(output valid, operation, led_index, on_level, interval, blink_count,
                 input ready);
  modport sink(input valid, operation, led_index, on_level, interval, blink_count,
               output ready);
endinterface

interface mlbc_res_if;
  import mlbc_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [SHOWN_LEDS-1:0] led_levels;
  logic [SHOWN_LEDS-1:0] blinking;

  modport source(output valid, led_levels, blinking, input ready);
  modport sink(input valid, led_levels, blinking, output ready);
endinterface

### sv/mlbc_tick_unit.sv
// One tick step for a single LED: count, flip, counted-blink bookkeeping.
// Depends on mlbc_pkg.
module mlbc_tick_unit (
  input  logic                   mode_in,
  input  logic                   level_in,
  input  mlbc_pkg::led_entry_t   entry_in,
  output logic                   mode_out,
  output logic                   level_out,
  output mlbc_pkg::led_entry_t   entry_out
);
  import mlbc_pkg::*;

  logic [CNT_W-1:0] count_inc;
  logic [CNT_W-1:0] rem_dec;
  logic             flipped;

  always_comb begin
    count_inc = entry_in.elapsed_ticks + CNT_W'(1);
    flipped   = ~level_in;
    rem_dec   = entry_in.cycles_remaining;
    if (rem_dec != '0) begin
      rem_dec = rem_dec - CNT_W'(1);
    end
    mode_out  = mode_in;
    level_out = level_in;
    entry_out = entry_in;
    if (mode_in) begin
      if (count_inc < entry_in.flip_interval) begin
        entry_out.elapsed_ticks = count_inc;
      end else begin
        entry_out.elapsed_ticks = '0;
        level_out = flipped;
        if (!entry_in.endless && (flipped == entry_in.saved_level)) begin
          entry_out.cycles_remaining = rem_dec;
          if (rem_dec == '0) begin
            mode_out = 1'b0;
          end
        end
      end
    end
  end

endmodule

### sv/mlbc_engine.sv
// Sequencer around the per-LED state memory; levels and modes in flops.
// Depends on mlbc_pkg, mlbc_if, mlbc_tick_unit.
module mlbc_engine #(
  parameter int NUM_LEDS = mlbc_pkg::NUM_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mlbc_cmd_if.sink    cmd,
  mlbc_res_if.source  res
);
  import mlbc_pkg::*;

  localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

  localparam logic [1:0] S_IDLE    = 2'd0;
  localparam logic [1:0] S_TICK    = 2'd1;
  localparam logic [1:0] S_RESTORE = 2'd2;
  localparam logic [1:0] S_DONE    = 2'd3;

  logic [1:0]          st;
  logic [NUM_LEDS-1:0] levels;
  logic [NUM_LEDS-1:0] modes;
  logic [IDX_W-1:0]    ptr;
  logic [IDX_W-1:0]    idx_q;
  logic                out_valid;
  logic [SHOWN_LEDS-1:0] out_levels;
  logic [SHOWN_LEDS-1:0] out_blink;
  logic [SHOWN_LEDS-1:0] cur_levels;
  logic [SHOWN_LEDS-1:0] cur_blink;

  led_entry_t          mem [NUM_LEDS];
  led_entry_t          rd_data;
  led_entry_t          wr_data;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    wr_addr;
  logic                we;

  logic                accept;
  logic [IDX_W-1:0]    idx;
  logic                idx_ok;
  logic                period_nz;
  logic                count_nz;
  logic                start_blink;
  logic                out_free;

  logic                tick_mode;
  logic                tick_level;
  led_entry_t          tick_entry;

  assign cmd.ready = (st == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign idx       = IDX_W'(cmd.led_index);
  assign idx_ok    = 32'(cmd.led_index) < NUM_LEDS;
  assign period_nz = cmd.interval != '0;
  assign count_nz  = cmd.blink_count != '0;
  assign out_free  = !out_valid || res.ready;

  always_comb begin
    start_blink = 1'b0;
    if (accept && idx_ok) begin
      case (cmd.operation)
        OP_BLINK_ON:     start_blink = period_nz;
        OP_BLINK_TOGGLE: start_blink = period_nz && !modes[idx];
        OP_BLINK_TIMES:  start_blink = period_nz && count_nz;
        default:         start_blink = 1'b0;
      endcase
    end
  end

  mlbc_tick_unit u_tick (
    .mode_in   (modes[ptr]),
    .level_in  (levels[ptr]),
    .entry_in  (rd_data),
    .mode_out  (tick_mode),
    .level_out (tick_level),
    .entry_out (tick_entry)
  );

  // Tick walks the LEDs: read of ptr+1 overlaps write-back of ptr.
  always_comb begin
    rd_addr = (cmd.operation == OP_TICK) ? '0 : idx;
    if (st == S_TICK) begin
      rd_addr = ptr + IDX_W'(1);
    end
    we      = 1'b0;
    wr_addr = idx;
    wr_data = '0;
    if (st == S_TICK) begin
      we      = modes[ptr];
      wr_addr = ptr;
      wr_data = tick_entry;
    end else if (start_blink) begin
      we                       = 1'b1;
      wr_data.saved_level      = levels[idx];
      wr_data.endless          = (cmd.operation != OP_BLINK_TIMES);
      wr_data.flip_interval    = cmd.interval;
      wr_data.elapsed_ticks    = '0;
      wr_data.cycles_remaining = (cmd.operation == OP_BLINK_TIMES) ? cmd.blink_count : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_IDLE;
      levels    <= '0;
      modes     <= '0;
      ptr       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (st == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (res.valid && res.ready) begin
        out_valid <= 1'b0;
      end
      case (st)
        S_IDLE: begin
          if (accept) begin
            if (cmd.operation == OP_TICK) begin
              ptr <= '0;
              st  <= S_TICK;
            end else begin
              st <= S_DONE;
              if (idx_ok) begin
                case (cmd.operation)
                  OP_SET: begin
                    modes[idx]  <= 1'b0;
                    levels[idx] <= cmd.on_level;
                  end
                  OP_TOGGLE: begin
                    modes[idx]  <= 1'b0;
                    levels[idx] <= ~levels[idx];
                  end
                  OP_BLINK_OFF: begin
                    if (modes[idx]) st <= S_RESTORE;
                  end
                  OP_BLINK_TOGGLE: begin
                    if (period_nz && modes[idx]) st <= S_RESTORE;
                  end
                  default: ;
                endcase
                if (start_blink) begin
                  modes[idx] <= 1'b1;
                end
              end
            end
          end
        end
        S_TICK: begin
          levels[ptr] <= tick_level;
          modes[ptr]  <= tick_mode;
          if (ptr == LAST_IDX) begin
            st <= S_DONE;
          end else begin
            ptr <= ptr + IDX_W'(1);
          end
        end
        S_RESTORE: begin
          levels[idx_q] <= rd_data.saved_level;
          modes[idx_q]  <= 1'b0;
          st            <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            st <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  for (genvar i = 0; i < SHOWN_LEDS; i++) begin : g_show
    if (i < NUM_LEDS) begin : g_on
      assign cur_levels[i] = levels[i];
      assign cur_blink[i]  = modes[i];
    end else begin : g_off
      assign cur_levels[i] = 1'b0;
      assign cur_blink[i]  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_q <= idx;
    end
    if (st == S_DONE && out_free) begin
      out_levels <= cur_levels;
      out_blink  <= cur_blink;
    end
  end

  assign res.valid      = out_valid;
  assign res.led_levels = out_levels;
  assign res.blinking   = out_blink;

endmodule

### sv/multi_led_blink_controller_top.sv
// Multi-LED blink controller. Tick reads every LED's memory entry in S_TICK and
// writes back only blinking ones, then registers the result in S_DONE. Set,
// toggle and blink start go to S_DONE; blink stop first passes S_RESTORE (saved
// level read from memory). Ready returns at the edge that registers the result.
// Reset (synchronous) clears levels, modes and handshake; the timing memory is
// not cleared, every entry is written at blink start before its data is used.
module multi_led_blink_controller_top #(
  parameter int NUM_LEDS = mlbc_pkg::NUM_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  mlbc_cmd_if.sink    cmd,
  mlbc_res_if.source  res
);
  import mlbc_pkg::*;

  localparam logic [SHOWN_LEDS-1:0] LED_MASK =
    (NUM_LEDS >= SHOWN_LEDS) ? '1 : SHOWN_LEDS'((1 << NUM_LEDS) - 1);

  mlbc_engine #(
    .NUM_LEDS (NUM_LEDS)
  ) u_engine (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .res (res)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("engine ready right after accepting a beat");

  a_tick_walk: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready && cmd.operation == OP_TICK) |-> ##(NUM_LEDS + 1) !cmd.ready)
    else $error("tick finished before visiting every LED");

  a_unused_leds: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (((res.led_levels | res.blinking) & ~LED_MASK) == '0))
    else $error("result shows an LED that does not exist");

endmodule
